// File: sv/fixed_point_log2_u16_top_macros.svh
// Assertion macros for the fixed-point log2 block checker
`ifndef FIXED_POINT_LOG2_U16_TOP_MACROS_SVH
`define FIXED_POINT_LOG2_U16_TOP_MACROS_SVH

// Overlapping implication, clocked on clk_i, off while reset is held
`define FPL2_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpl2 assertion failed");

// Non-overlapping implication, clocked on clk_i, off while reset is held
`define FPL2_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpl2 assertion failed");

`endif

// File: sv/fpl2_pkg.sv
// Shared types and constants of the fixed-point log2 pipeline
`default_nettype none

package fpl2_pkg;

  // Edges from request acceptance to the edge that takes the result
  localparam int unsigned LATENCY = 5;

  // Polynomial coefficients (fraction in s15, scaled by 8)
  localparam logic [5:0]  COEF_C0     = 6'd37;
  localparam logic [15:0] COEF_C1     = 16'd46390;
  localparam logic [14:0] COEF_C2_MAG = 15'd18778;
  localparam logic [12:0] COEF_C3     = 13'd5155;

  // Rounding bias for the ceiling of the negative term
  localparam logic [14:0] ROUND_S15   = 15'h7FFF;

  // Saturation limit of the 4.12 result
  localparam logic [15:0] LOG_MAX     = 16'hFFFF;

  // Normalised operand after stage 1
  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [3:0]  expo;
    logic [14:0] mant;
  } norm_t;

  // Partial polynomial after stage 4
  typedef struct packed {
    logic               valid;
    logic               zero;
    logic [3:0]         expo;
    logic signed [17:0] psum;
    logic [12:0]        t3;
  } part_t;

endpackage

`default_nettype wire

// File: sv/fpl2_norm.sv
// Stage 1: leading-one search and normalisation of the input
`default_nettype none

module fpl2_norm
  import fpl2_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_i,
  input  wire logic [15:0] value_i,
  output norm_t            norm_o
);

  logic [15:0] x8, x4, x2, x1;
  logic [3:0]  shift;
  logic        valid_q;
  logic        zero_q;
  logic [3:0]  expo_q;
  logic [14:0] mant_q;

  // Left-normalise in steps of 8, 4, 2 and 1
  always_comb begin
    shift = 4'd0;
    x8 = value_i;
    if (x8[15:8] == 8'd0) begin
      x8 = x8 << 8;
      shift[3] = 1'b1;
    end
    x4 = x8;
    if (x4[15:12] == 4'd0) begin
      x4 = x4 << 4;
      shift[2] = 1'b1;
    end
    x2 = x4;
    if (x2[15:14] == 2'd0) begin
      x2 = x2 << 2;
      shift[1] = 1'b1;
    end
    x1 = x2;
    if (!x1[15]) begin
      x1 = x1 << 1;
      shift[0] = 1'b1;
    end
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i;
    end
  end

  // Payload: exponent is 15 minus shift, mantissa drops the leading one
  always_ff @(posedge clk_i) begin
    zero_q <= (value_i == 16'd0);
    expo_q <= ~shift;
    mant_q <= x1[14:0];
  end

  assign norm_o = '{valid: valid_q, zero: zero_q, expo: expo_q, mant: mant_q};

endmodule

`default_nettype wire

// File: sv/fpl2_poly.sv
// Stages 2 to 4: powers of the mantissa and the polynomial terms
`default_nettype none

module fpl2_poly
  import fpl2_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire norm_t norm_i,
  output part_t      part_o
);

  // Stage 2 signals
  logic [29:0] m2_full;
  logic [30:0] t1_full;
  logic        s2_valid_q, s2_zero_q;
  logic [3:0]  s2_expo_q;
  logic [14:0] s2_mant_q, s2_m2_q;
  logic [15:0] s2_t1_q;

  // Stage 3 signals
  logic [29:0] m3_full;
  logic [30:0] t2_full;
  logic        s3_valid_q, s3_zero_q;
  logic [3:0]  s3_expo_q;
  logic [14:0] s3_m3_q;
  logic [15:0] s3_t1_q, s3_t2_q;

  // Stage 4 signals
  logic [27:0]        t3_full;
  logic signed [17:0] psum;
  logic               s4_valid_q, s4_zero_q;
  logic [3:0]         s4_expo_q;
  logic signed [17:0] s4_psum_q;
  logic [12:0]        s4_t3_q;

  // Stage 2: m squared and the linear term
  assign m2_full = 30'(norm_i.mant) * 30'(norm_i.mant);
  assign t1_full = 31'(COEF_C1) * 31'(norm_i.mant);

  // Stage 3: m cubed and the quadratic term, rounded up before negation
  assign m3_full = 30'(s2_m2_q) * 30'(s2_mant_q);
  assign t2_full = 31'(30'(COEF_C2_MAG) * 30'(s2_m2_q)) + 31'(ROUND_S15);

  // Stage 4: cubic term and the constant, linear and quadratic sum
  assign t3_full = 28'(COEF_C3) * 28'(s3_m3_q);
  assign psum    = $signed({2'b00, s3_t1_q}) + $signed(18'(COEF_C0))
                   - $signed({2'b00, s3_t2_q});

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= norm_i.valid;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s2_zero_q <= norm_i.zero;
    s2_expo_q <= norm_i.expo;
    s2_mant_q <= norm_i.mant;
    s2_m2_q   <= m2_full[29:15];
    s2_t1_q   <= t1_full[30:15];

    s3_zero_q <= s2_zero_q;
    s3_expo_q <= s2_expo_q;
    s3_m3_q   <= m3_full[29:15];
    s3_t1_q   <= s2_t1_q;
    s3_t2_q   <= t2_full[30:15];

    s4_zero_q <= s3_zero_q;
    s4_expo_q <= s3_expo_q;
    s4_psum_q <= psum;
    s4_t3_q   <= t3_full[27:15];
  end

  assign part_o = '{valid: s4_valid_q, zero: s4_zero_q, expo: s4_expo_q,
                    psum: s4_psum_q, t3: s4_t3_q};

endmodule

`default_nettype wire

// File: sv/fpl2_sum.sv
// Stage 5: final polynomial sum, scaling, exponent add and saturation
`default_nettype none

module fpl2_sum
  import fpl2_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire part_t       part_i,
  output logic             valid_o,
  output logic [15:0]      log_o
);

  logic signed [17:0] poly;
  logic [14:0]        frac;
  logic [16:0]        total;
  logic [15:0]        log_d, log_q;
  logic               valid_q;

  // Add cubic term, clamp at zero, scale by 1/8, add integer part, saturate; zero input gives zero
  always_comb begin
    poly  = part_i.psum + $signed({5'b00000, part_i.t3});
    frac  = poly[17] ? 15'd0 : poly[17:3];
    total = {1'b0, part_i.expo, 12'd0} + {2'b00, frac};
    if (part_i.zero) begin
      log_d = 16'd0;
    end else if (total[16]) begin
      log_d = LOG_MAX;
    end else begin
      log_d = total[15:0];
    end
  end

  // Strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= part_i.valid;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    log_q <= log_d;
  end

  assign valid_o = valid_q;
  assign log_o   = log_q;

endmodule

`default_nettype wire

// File: sv/fixed_point_log2_u16_top.sv
// Log2 of an unsigned 16-bit value in 4.12, five-stage pipeline.
// Throughput: one request per cycle; busy_o stays low, the stages never stall.
// Stage depth: normalise, one multiply level in each of stages 2 to 4, then the final add.
// Reset clears the valid bits only; no result is strobed for requests in flight.
`default_nettype none

module fixed_point_log2_u16_top
  import fpl2_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] linear_value_i,
  output logic             busy_o,
  output logic             valid_o,
  output logic [15:0]      log_value_o
);

  norm_t norm;
  part_t part;
  logic  req;

  // Request accepted whenever start is high; never busy
  assign busy_o = 1'b0;
  assign req    = start_i & ~busy_o;

  fpl2_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .value_i (linear_value_i),
    .norm_o  (norm)
  );

  fpl2_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .norm_i (norm),
    .part_o (part)
  );

  fpl2_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .part_i  (part),
    .valid_o (valid_o),
    .log_o   (log_value_o)
  );

endmodule

`default_nettype wire

// File: sv/fpl2_checker.sv
// Port-level checker for the log2 pipeline, bound to the top level
`default_nettype none

`include "fixed_point_log2_u16_top_macros.svh"

module fpl2_checker
  import fpl2_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic [15:0] linear_value_i,
  input wire logic        busy_o,
  input wire logic        valid_o,
  input wire logic [15:0] log_value_o
);

  logic acc;
  assign acc = start_i && !busy_o;

  // Every request yields a strobe after the pipeline latency
  `FPL2_ASSERT_IMPL(a_req_strobe, acc, ##LATENCY valid_o)

  // No strobe without a request that many cycles earlier
  `FPL2_ASSERT_IMPL(a_no_spurious, valid_o, $past(acc, LATENCY))

  // Zero input gives zero
  `FPL2_ASSERT_IMPL(a_zero_in, acc && (linear_value_i == 16'd0),
                    ##LATENCY (valid_o && (log_value_o == 16'd0)))

  // Input with top bit set lands in the top octave
  `FPL2_ASSERT_NEXT(a_top_octave, acc && linear_value_i[15],
                    ##(LATENCY - 1) (valid_o && (log_value_o[15:12] == 4'hF)))

endmodule

bind fixed_point_log2_u16_top fpl2_checker u_fpl2_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .linear_value_i (linear_value_i),
  .busy_o         (busy_o),
  .valid_o        (valid_o),
  .log_value_o    (log_value_o)
);

`default_nettype wire

// File: tb/fixed_point_log2_u16_top_tb.sv
// Self-checking testbench for the unsigned 16-bit to 4.12 log2 pipeline
`timescale 1ns / 100ps

module fixed_point_log2_u16_top_tb;

  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned RANDOM_ITEMS   = 400;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = fpl2_pkg::LATENCY + 8;

  // Polynomial terms of the log2 fraction, all in s15
  localparam longint FRAC_C0     = 37;
  localparam longint FRAC_C1     = 46390;
  localparam longint FRAC_C2_MAG = 18778;
  localparam longint FRAC_C3     = 5155;
  localparam longint S15_ONE     = 32768;

  typedef struct packed {
    logic [15:0] operand;
    logic        typed;
    logic [15:0] log_value;
  } stim_row_t;

  typedef struct packed {
    logic [15:0] operand;
    logic [15:0] log_value;
  } log_expect_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start_i        = 1'b0;
  logic [15:0] linear_value_i = '0;
  logic        busy_o;
  logic        valid_o;
  logic [15:0] log_value_o;

  // Typed result travels alongside the request it belongs to
  logic        req_typed      = 1'b0;
  logic [15:0] req_typed_log  = '0;

  log_expect_t pending_logs[$];
  int unsigned requests_sent  = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned saturated_seen = 0;
  int unsigned zero_inputs    = 0;
  int unsigned idle_cycles    = 0;

  // Extremes, powers of two and both sides of the saturation point
  stim_row_t directed_rows [22] = '{
    '{16'h0000, 1'b1, 16'h0000},
    '{16'h0001, 1'b1, 16'h0004},
    '{16'h0002, 1'b1, 16'h1004},
    '{16'h8000, 1'b1, 16'hF004},
    '{16'hFFFF, 1'b1, 16'hFFFF},
    '{16'h0003, 1'b0, 16'h0000},
    '{16'h000F, 1'b0, 16'h0000},
    '{16'h0010, 1'b0, 16'h0000},
    '{16'h0011, 1'b0, 16'h0000},
    '{16'h00FF, 1'b0, 16'h0000},
    '{16'h0100, 1'b0, 16'h0000},
    '{16'h0101, 1'b0, 16'h0000},
    '{16'h0FFF, 1'b0, 16'h0000},
    '{16'h1000, 1'b0, 16'h0000},
    '{16'h5555, 1'b0, 16'h0000},
    '{16'hAAAA, 1'b0, 16'h0000},
    '{16'h7FFF, 1'b0, 16'h0000},
    '{16'h8001, 1'b0, 16'h0000},
    '{16'hF000, 1'b0, 16'h0000},
    '{16'hFF80, 1'b0, 16'h0000},
    '{16'hFFF0, 1'b0, 16'h0000},
    '{16'hFFFE, 1'b0, 16'h0000}
  };

  fixed_point_log2_u16_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .linear_value_i (linear_value_i),
    .busy_o         (busy_o),
    .valid_o        (valid_o),
    .log_value_o    (log_value_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // log2 in 4.12: shift-normalise for the integer part, cubic for the fraction
  function automatic logic [15:0] log2_q412(input logic [15:0] value);
    logic [31:0] norm;
    logic [31:0] acc;
    longint      frac;
    longint      frac_sq;
    longint      frac_cube;
    longint      poly;
    acc  = '0;
    norm = {value, 16'h0000};
    if (value == 16'h0000) begin
      return 16'h0000;
    end
    if (norm >= 32'h0100_0000) begin
      acc += 32'd8 << 12;
      norm = norm >> 8;
    end
    if (norm >= 32'h0010_0000) begin
      acc += 32'd4 << 12;
      norm = norm >> 4;
    end
    if (norm >= 32'h0004_0000) begin
      acc += 32'd2 << 12;
      norm = norm >> 2;
    end
    if (norm >= 32'h0002_0000) begin
      acc += 32'd1 << 12;
      norm = norm >> 1;
    end
    norm      = norm >> 1;
    frac      = longint'(norm) - S15_ONE;
    frac_sq   = (frac * frac) >> 15;
    frac_cube = (frac_sq * frac) >> 15;
    // negative term is floored, i.e. its magnitude is rounded up
    poly = FRAC_C0
         + ((FRAC_C1 * frac) >> 15)
         - ((FRAC_C2_MAG * frac_sq + S15_ONE - 1) >> 15)
         + ((FRAC_C3 * frac_cube) >> 15);
    if (poly < 0) begin
      poly = 0;
    end
    acc += 32'(poly >> 3);
    if (acc > 32'h0000_FFFF) begin
      return 16'hFFFF;
    end
    return acc[15:0];
  endfunction

  // Mixed random operands: uniform, small, near full scale, around powers of two, shifted down
  function automatic logic [15:0] pick_operand();
    logic [15:0] pow2;
    pow2 = 16'h0001 << $urandom_range(0, 15);
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 255));
      1:       return 16'hFFFF - 16'($urandom_range(0, 300));
      2:       return pow2 + 16'($urandom_range(0, 2)) - 16'd1;
      3:       return 16'($urandom >> $urandom_range(0, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one request, hold it until taken, then idle for the given gap
  task automatic send_request(input logic [15:0] operand, input logic typed,
                              input logic [15:0] typed_log, input int unsigned gap);
    bit taken;
    start_i        <= 1'b1;
    linear_value_i <= operand;
    req_typed      <= typed;
    req_typed_log  <= typed_log;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    if (gap != 0) begin
      start_i   <= 1'b0;
      req_typed <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Request capture and result check, on the values before each edge
  always @(posedge clk_i) begin
    log_expect_t got_expect;
    log_expect_t new_expect;
    if (rst_ni) begin
      if (valid_o) begin
        results_seen++;
        if (log_value_o == 16'hFFFF) begin
          saturated_seen++;
        end
        if (pending_logs.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result %h strobed with no request outstanding",
                     $realtime, log_value_o);
          end
        end else begin
          got_expect = pending_logs.pop_front();
          if (log_value_o !== got_expect.log_value) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: log_value for input %h: expected %h, got %h",
                       $realtime, got_expect.operand, got_expect.log_value,
                       log_value_o);
            end
          end
        end
      end
      if (start_i && !busy_o) begin
        new_expect.operand   = linear_value_i;
        new_expect.log_value = req_typed ? req_typed_log : log2_q412(linear_value_i);
        pending_logs.push_back(new_expect);
        requests_sent++;
        if (linear_value_i == 16'h0000) begin
          zero_inputs++;
        end
      end
    end
  end

  // Watchdog: too long without a request taken or a result strobed
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed table, then random bursts
  initial begin
    int unsigned burst_left;
    int unsigned gap;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].operand, directed_rows[i].typed,
                   directed_rows[i].log_value, $urandom_range(0, 2));
    end

    burst_left = $urandom_range(1, 24);
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
      send_request(pick_operand(), 1'b0, 16'h0000, gap);
    end
    start_i   <= 1'b0;
    req_typed <= 1'b0;

    while (pending_logs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests (%0d zero operands), checked %0d results, %0d saturated",
             requests_sent, zero_inputs, results_seen, saturated_seen);
    $display("Mismatches or unexpected results: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/fpl2_pkg.sv
sv/fpl2_norm.sv
sv/fpl2_poly.sv
sv/fpl2_sum.sv
sv/fixed_point_log2_u16_top.sv
sv/fpl2_checker.sv
tb/fixed_point_log2_u16_top_tb.sv
